// ----- design/ees_pkg.sv -----
// ----------------------------------------------------------------------------
// ees_pkg: shared types and constants of the ellipse edge-point scorer
// Field widths, register map codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ees_pkg;

    localparam int COORD_W  = 16;
    localparam int REL_W    = 24;
    localparam int ABS_W    = 25;
    localparam int MEAN_W   = 24;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    localparam int MAX_ARC_POINTS_DEF   = 4096;
    localparam int MAX_GROUP_POINTS_DEF = 65536;

    localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
    // pi in Q2.30
    localparam logic [31:0] PI_Q30   = 32'd3373259426;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_SEMI_MAJ  = 3'd2,
        REG_SEMI_MIN  = 3'd3,
        REG_COS       = 3'd4,
        REG_SIN       = 3'd5,
        REG_THRESHOLD = 3'd6
    } reg_idx_t;

endpackage

// ----- design/ees_point_if.sv -----
// ----------------------------------------------------------------------------
// ees_point_if: edge point channel
// One beat carries one edge point and its arc and group end marks.
// ----------------------------------------------------------------------------
interface ees_point_if;
    logic                         valid;
    logic                         ready;
    logic [ees_pkg::COORD_W-1:0]  point_x;
    logic [ees_pkg::COORD_W-1:0]  point_y;
    logic                         arc_last;
    logic                         group_last;

    modport source (output valid, point_x, point_y, arc_last, group_last, input ready);
    modport sink   (input valid, point_x, point_y, arc_last, group_last, output ready);
endinterface

// ----- design/ees_result_if.sv -----
// ----------------------------------------------------------------------------
// ees_result_if: group score channel
// One beat carries the scores of one finished arc group.
// ----------------------------------------------------------------------------
interface ees_result_if;
    logic                        valid;
    logic                        ready;
    logic [ees_pkg::REL_W-1:0]   relative_support;
    logic [ees_pkg::ABS_W-1:0]   absolute_support;
    logic [ees_pkg::MEAN_W-1:0]  mean_fit_error;

    modport source (output valid, relative_support, absolute_support, mean_fit_error,
                    input ready);
    modport sink   (input valid, relative_support, absolute_support, mean_fit_error,
                    output ready);
endinterface

// ----- design/ellipse_edgel_support.sv -----
// ----------------------------------------------------------------------------
// ellipse_edgel_support: ellipse hypothesis scoring over edge points
// Rotates each point into ellipse coordinates, finds its gradient-weighted
// algebraic distance, keeps arc and group support sums and emits the scores
// at group end.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat contents
//  -------  ---  -----------------------------------------------------------
//  pt       in   point_x, point_y (Q12.4), arc_last, group_last
//  res      out  relative_support Q8.16, absolute_support Q17.8,
//                mean_fit_error Q16.8 (one beat per group)
//  apb      cfg  seven 16-bit registers at byte address 4*index
//
//  A point runs 34 micro-steps on the shared 33x33 multiplier, a 64-step
//  integer square root and a 25-step restoring divide, all sharing one
//  128-bit accumulator; a point at the centre stops after the rotation.
//  An arc end adds one divide; a group end adds the circumference root
//  and two divides. pt.ready is high only in idle.
//  A finished score waits in the output register; the next point is taken
//  meanwhile, and only the next group end stalls until res is free.
//  Reset clears all counters and sums and loads the register defaults.
//
module ellipse_edgel_support #(
    parameter int MAX_ARC_POINTS   = ees_pkg::MAX_ARC_POINTS_DEF,
    parameter int MAX_GROUP_POINTS = ees_pkg::MAX_GROUP_POINTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ees_pkg::ADDR_W-1:0]  paddr,
    input  logic [ees_pkg::DATA_W-1:0]  pwdata,
    output logic [ees_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    ees_point_if.sink                   pt,
    ees_result_if.source                res
);

    localparam int ARC_W = $clog2(MAX_ARC_POINTS + 1);
    localparam int GRP_W = $clog2(MAX_GROUP_POINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PT, S_SQRT, S_DIV, S_BOOK, S_ARC_MUL, S_ARC_SET,
        S_GRP_MUL, S_GRP_SET, S_CIRC_MUL, S_CIRC_CAP, S_MEAN_SET, S_OUT
    } state_t;

    typedef enum logic [1:0] { DV_DIST, DV_ARC, DV_REL, DV_MEAN } div_use_t;
    typedef enum logic { SQ_PT, SQ_CIRC } sqrt_use_t;
    typedef enum logic [1:0] { ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB } acc_op_t;

    // sequencer
    state_t     state_reg, state_next;
    logic [5:0] pc_reg, pc_next;
    logic [5:0] iter_reg, iter_next;
    div_use_t   dv_reg, dv_next;
    sqrt_use_t  sq_reg, sq_next;

    // configuration
    logic [15:0] cx_reg, cy_reg, sa_reg, sb_reg, cos_reg, sin_reg, thr_reg;
    logic        cfg_wr;

    // current point
    logic [15:0] ptx_reg, ptx_next, pty_reg, pty_next;
    logic        arc_end_reg, arc_end_next, grp_end_reg, grp_end_next;

    // datapath
    logic signed [127:0] acc_reg, acc_next;
    logic signed [23:0]  qx_reg, qx_next, qy_reg, qy_next;
    logic [42:0]         uxb_reg, uxb_next, uya_reg, uya_next;
    logic [62:0]         uxbb_reg, uxbb_next, uyaa_reg, uyaa_next;
    logic [39:0]         ab_reg, ab_next;
    logic [63:0]         root_reg, root_next;
    logic [67:0]         rem_reg, rem_next;
    logic [89:0]         dsh_reg, dsh_next;
    logic [24:0]         quo_reg, quo_next;
    logic [23:0]         dist_reg, dist_next;
    logic [23:0]         rel_reg, rel_next, mean_reg, mean_next;

    // sums
    logic [ARC_W-1:0] sup_cnt_reg, sup_cnt_next, arc_cnt_reg, arc_cnt_next;
    logic [GRP_W-1:0] gpc_reg, gpc_next;
    logic [31:0]      sup_total_reg, sup_total_next;
    logic [47:0]      dist_total_reg, dist_total_next;

    // output register
    logic        res_valid_reg, res_valid_next;
    logic [23:0] res_rel_reg, res_rel_next;
    logic [24:0] res_abs_reg, res_abs_next;
    logic [23:0] res_mean_reg, res_mean_next;

    // shared multiplier
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  prod;
    logic signed [127:0] prod_sh;
    logic [6:0]          acc_sh;
    acc_op_t             acc_op;

    // helpers
    logic signed [16:0] px, py;
    logic [35:0]        rnd_sum;
    logic [23:0]        rnd_q;
    logic [23:0]        qx_neg, qy_neg;
    logic [22:0]        ux, uy;
    logic [19:0]        ax4, bx4;
    logic [67:0]        rem_sh, trial;
    logic               sq_ge, dv_ge;
    logic [16:0]        ab_sum;
    logic [21:0]        inner;
    logic [55:0]        circ_sum;
    logic [24:0]        circ_w;
    logic [32:0]        sup_sum;
    logic [48:0]        dist_sum;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (ees_pkg::reg_idx_t'(paddr[4:2]))
            ees_pkg::REG_CENTER_X:  prdata = 32'(cx_reg);
            ees_pkg::REG_CENTER_Y:  prdata = 32'(cy_reg);
            ees_pkg::REG_SEMI_MAJ:  prdata = 32'(sa_reg);
            ees_pkg::REG_SEMI_MIN:  prdata = 32'(sb_reg);
            ees_pkg::REG_COS:       prdata = 32'(cos_reg);
            ees_pkg::REG_SIN:       prdata = 32'(sin_reg);
            ees_pkg::REG_THRESHOLD: prdata = 32'(thr_reg);
            default:                prdata = '0;
        endcase
    end

    assign pt.ready                = (state_reg == S_IDLE);
    assign res.valid               = res_valid_reg;
    assign res.relative_support    = res_rel_reg;
    assign res.absolute_support    = res_abs_reg;
    assign res.mean_fit_error      = res_mean_reg;

    assign prod    = mul_a * mul_b;
    assign prod_sh = 128'(prod) <<< acc_sh;

    // point relative to the centre, Q.4
    assign px = $signed({1'b0, ptx_reg}) - $signed({1'b0, cx_reg});
    assign py = $signed({1'b0, pty_reg}) - $signed({1'b0, cy_reg});

    // Q.18 rotation sum -> Q.8, round half up
    assign rnd_sum = acc_reg[35:0] + 36'd512;
    assign rnd_q   = rnd_sum[33:10];

    assign qx_neg = -qx_reg;
    assign qy_neg = -qy_reg;
    assign ux     = qx_reg[23] ? qx_neg[22:0] : qx_reg[22:0];
    assign uy     = qy_reg[23] ? qy_neg[22:0] : qy_reg[22:0];
    assign ax4    = {sa_reg, 4'b0};
    assign bx4    = {sb_reg, 4'b0};

    // digit-by-digit root step, radicand consumed from the top of acc
    assign rem_sh = {rem_reg[65:0], acc_reg[127:126]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = (rem_sh >= trial);

    // restoring divide step
    assign dv_ge  = (acc_reg[89:0] >= dsh_reg);

    // 24*(a+b) - sqrt(256ab) in Q.4 * 6 terms
    assign ab_sum   = {1'b0, sa_reg} + {1'b0, sb_reg};
    assign inner    = ({1'b0, ab_sum, 4'b0} + {2'b0, ab_sum, 3'b0}) - root_reg[21:0];
    assign circ_sum = acc_reg[55:0] + 56'd536870912;
    assign circ_w   = circ_sum[54:30];

    // final arc quotient, taken straight from the last divide step
    assign sup_sum  = {1'b0, sup_total_reg} + 33'({quo_reg[23:0], dv_ge});
    assign dist_sum = {1'b0, dist_total_reg} + 49'(dist_reg);

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        iter_next       = iter_reg;
        dv_next         = dv_reg;
        sq_next         = sq_reg;
        ptx_next        = ptx_reg;
        pty_next        = pty_reg;
        arc_end_next    = arc_end_reg;
        grp_end_next    = grp_end_reg;
        acc_next        = acc_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        uxb_next        = uxb_reg;
        uya_next        = uya_reg;
        uxbb_next       = uxbb_reg;
        uyaa_next       = uyaa_reg;
        ab_next         = ab_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quo_next        = quo_reg;
        dist_next       = dist_reg;
        rel_next        = rel_reg;
        mean_next       = mean_reg;
        sup_cnt_next    = sup_cnt_reg;
        arc_cnt_next    = arc_cnt_reg;
        gpc_next        = gpc_reg;
        sup_total_next  = sup_total_reg;
        dist_total_next = dist_total_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_rel_next    = res_rel_reg;
        res_abs_next    = res_abs_reg;
        res_mean_next   = res_mean_reg;
        mul_a           = '0;
        mul_b           = '0;
        acc_sh          = 7'd0;
        acc_op          = ACC_HOLD;

        case (state_reg)
            S_IDLE:
            begin
                if (pt.valid)
                begin
                    ptx_next     = pt.point_x;
                    pty_next     = pt.point_y;
                    arc_end_next = pt.arc_last;
                    grp_end_next = pt.group_last;
                    pc_next      = 6'd0;
                    state_next   = S_PT;
                end
            end

            S_PT:
            begin
                pc_next = pc_reg + 6'd1;
                case (pc_reg)
                    // rotation by minus the angle
                    6'd0:
                    begin
                        mul_a = 33'($signed(cos_reg)); mul_b = 33'(px); acc_op = ACC_LOAD;
                    end
                    6'd1:
                    begin
                        mul_a = 33'($signed(sin_reg)); mul_b = 33'(py); acc_op = ACC_ADD;
                    end
                    6'd2:
                    begin
                        qx_next = rnd_q;
                        mul_a = 33'($signed(cos_reg)); mul_b = 33'(py); acc_op = ACC_LOAD;
                    end
                    6'd3:
                    begin
                        mul_a = 33'($signed(sin_reg)); mul_b = 33'(px); acc_op = ACC_SUB;
                    end
                    6'd4:  qy_next = rnd_q;
                    6'd5:
                    begin
                        if (qx_reg == '0 && qy_reg == '0)
                        begin
                            // point at the centre scores the minor axis
                            dist_next  = 24'(bx4);
                            state_next = S_BOOK;
                        end
                        else
                        begin
                            mul_a = 33'(ux); mul_b = 33'(bx4); acc_op = ACC_LOAD;
                        end
                    end
                    6'd6:
                    begin
                        uxb_next = acc_reg[42:0];
                        mul_a = 33'(uy); mul_b = 33'(ax4); acc_op = ACC_LOAD;
                    end
                    6'd7:
                    begin
                        uya_next = acc_reg[42:0];
                        mul_a = 33'(ax4); mul_b = 33'(bx4); acc_op = ACC_LOAD;
                    end
                    6'd8:
                    begin
                        ab_next = acc_reg[39:0];
                        mul_a = 33'(uxb_reg[31:0]); mul_b = 33'(bx4); acc_op = ACC_LOAD;
                    end
                    6'd9:
                    begin
                        mul_a = 33'(uxb_reg[42:32]); mul_b = 33'(bx4);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd10:
                    begin
                        uxbb_next = acc_reg[62:0];
                        mul_a = 33'(uya_reg[31:0]); mul_b = 33'(ax4); acc_op = ACC_LOAD;
                    end
                    6'd11:
                    begin
                        mul_a = 33'(uya_reg[42:32]); mul_b = 33'(ax4);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    // root term M = (ux B^2)^2 + (uy A^2)^2
                    6'd12:
                    begin
                        uyaa_next = acc_reg[62:0];
                        mul_a = 33'(uxbb_reg[31:0]); mul_b = 33'(uxbb_reg[31:0]);
                        acc_op = ACC_LOAD;
                    end
                    6'd13:
                    begin
                        mul_a = 33'(uxbb_reg[31:0]); mul_b = 33'(uxbb_reg[62:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd14:
                    begin
                        mul_a = 33'(uxbb_reg[62:32]); mul_b = 33'(uxbb_reg[31:0]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd15:
                    begin
                        mul_a = 33'(uxbb_reg[62:32]); mul_b = 33'(uxbb_reg[62:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd64;
                    end
                    6'd16:
                    begin
                        mul_a = 33'(uyaa_reg[31:0]); mul_b = 33'(uyaa_reg[31:0]);
                        acc_op = ACC_ADD;
                    end
                    6'd17:
                    begin
                        mul_a = 33'(uyaa_reg[31:0]); mul_b = 33'(uyaa_reg[62:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd18:
                    begin
                        mul_a = 33'(uyaa_reg[62:32]); mul_b = 33'(uyaa_reg[31:0]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd19:
                    begin
                        mul_a = 33'(uyaa_reg[62:32]); mul_b = 33'(uyaa_reg[62:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd64;
                    end
                    6'd20:
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        iter_next  = '0;
                        sq_next    = SQ_PT;
                        state_next = S_SQRT;
                    end
                    // numerator P - Q, P = (ux B)^2 + (uy A)^2, Q = (AB)^2
                    6'd21:
                    begin
                        mul_a = 33'(uxb_reg[31:0]); mul_b = 33'(uxb_reg[31:0]);
                        acc_op = ACC_LOAD;
                    end
                    6'd22:
                    begin
                        mul_a = 33'(uxb_reg[31:0]); mul_b = 33'(uxb_reg[42:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd23:
                    begin
                        mul_a = 33'(uxb_reg[42:32]); mul_b = 33'(uxb_reg[31:0]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd24:
                    begin
                        mul_a = 33'(uxb_reg[42:32]); mul_b = 33'(uxb_reg[42:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd64;
                    end
                    6'd25:
                    begin
                        mul_a = 33'(uya_reg[31:0]); mul_b = 33'(uya_reg[31:0]);
                        acc_op = ACC_ADD;
                    end
                    6'd26:
                    begin
                        mul_a = 33'(uya_reg[31:0]); mul_b = 33'(uya_reg[42:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd27:
                    begin
                        mul_a = 33'(uya_reg[42:32]); mul_b = 33'(uya_reg[31:0]);
                        acc_op = ACC_ADD; acc_sh = 7'd32;
                    end
                    6'd28:
                    begin
                        mul_a = 33'(uya_reg[42:32]); mul_b = 33'(uya_reg[42:32]);
                        acc_op = ACC_ADD; acc_sh = 7'd64;
                    end
                    6'd29:
                    begin
                        mul_a = 33'(ab_reg[31:0]); mul_b = 33'(ab_reg[31:0]);
                        acc_op = ACC_SUB;
                    end
                    6'd30:
                    begin
                        mul_a = 33'(ab_reg[31:0]); mul_b = 33'(ab_reg[39:32]);
                        acc_op = ACC_SUB; acc_sh = 7'd32;
                    end
                    6'd31:
                    begin
                        mul_a = 33'(ab_reg[39:32]); mul_b = 33'(ab_reg[31:0]);
                        acc_op = ACC_SUB; acc_sh = 7'd32;
                    end
                    6'd32:
                    begin
                        mul_a = 33'(ab_reg[39:32]); mul_b = 33'(ab_reg[39:32]);
                        acc_op = ACC_SUB; acc_sh = 7'd64;
                    end
                    6'd33:
                    begin
                        if (root_reg == '0)
                        begin
                            // degenerate axis
                            dist_next  = ees_pkg::DIST_MAX;
                            state_next = S_BOOK;
                        end
                        else
                        begin
                            acc_next   = acc_reg[127] ? -acc_reg : acc_reg;
                            dsh_next   = 90'({root_reg, 1'b0}) << 24;
                            quo_next   = '0;
                            iter_next  = '0;
                            dv_next    = DV_DIST;
                            state_next = S_DIV;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            S_SQRT:
            begin
                rem_next  = sq_ge ? rem_sh - trial : rem_sh;
                root_next = {root_reg[62:0], sq_ge};
                acc_next  = acc_reg <<< 2;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'd63)
                begin
                    case (sq_reg)
                        SQ_PT:
                        begin
                            pc_next    = 6'd21;
                            state_next = S_PT;
                        end
                        SQ_CIRC:  state_next = S_CIRC_MUL;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end

            S_DIV:
            begin
                if (dv_ge)
                begin
                    acc_next = 128'(acc_reg[89:0] - dsh_reg);
                end
                quo_next  = {quo_reg[23:0], dv_ge};
                dsh_next  = dsh_reg >> 1;
                iter_next = iter_reg + 6'd1;
                if (iter_reg == 6'd24)
                begin
                    case (dv_reg)
                        DV_DIST:
                        begin
                            dist_next  = quo_next[24] ? ees_pkg::DIST_MAX : quo_next[23:0];
                            state_next = S_BOOK;
                        end
                        DV_ARC:
                        begin
                            sup_total_next = sup_sum[32] ? '1 : sup_sum[31:0];
                            sup_cnt_next   = '0;
                            arc_cnt_next   = '0;
                            state_next     = grp_end_reg ? S_GRP_MUL : S_IDLE;
                        end
                        DV_REL:
                        begin
                            rel_next   = quo_next[24] ? ees_pkg::DIST_MAX : quo_next[23:0];
                            state_next = S_MEAN_SET;
                        end
                        DV_MEAN:
                        begin
                            mean_next  = quo_next[24] ? ees_pkg::DIST_MAX : quo_next[23:0];
                            state_next = S_OUT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_BOOK:
            begin
                if (arc_cnt_reg < ARC_W'(MAX_ARC_POINTS))
                begin
                    arc_cnt_next = arc_cnt_reg + 1'b1;
                    if (dist_reg <= 24'(thr_reg))
                    begin
                        sup_cnt_next = sup_cnt_reg + 1'b1;
                    end
                end
                if (gpc_reg < GRP_W'(MAX_GROUP_POINTS))
                begin
                    gpc_next        = gpc_reg + 1'b1;
                    dist_total_next = dist_sum[48] ? '1 : dist_sum[47:0];
                end
                state_next = (arc_end_reg || grp_end_reg) ? S_ARC_MUL : S_IDLE;
            end

            // arc support s^2 * 256 / n
            S_ARC_MUL:
            begin
                mul_a      = 33'(sup_cnt_reg);
                mul_b      = 33'(sup_cnt_reg);
                acc_op     = ACC_LOAD;
                state_next = S_ARC_SET;
            end

            S_ARC_SET:
            begin
                acc_next   = acc_reg <<< 8;
                dsh_next   = 90'(arc_cnt_reg) << 24;
                quo_next   = '0;
                iter_next  = '0;
                dv_next    = DV_ARC;
                state_next = S_DIV;
            end

            // circumference pi * (1.5(a+b) - sqrt(ab)) in Q.8
            S_GRP_MUL:
            begin
                mul_a      = 33'(sa_reg);
                mul_b      = 33'(sb_reg);
                acc_op     = ACC_LOAD;
                state_next = S_GRP_SET;
            end

            S_GRP_SET:
            begin
                acc_next   = acc_reg <<< 8;
                rem_next   = '0;
                root_next  = '0;
                iter_next  = '0;
                sq_next    = SQ_CIRC;
                state_next = S_SQRT;
            end

            S_CIRC_MUL:
            begin
                mul_a      = 33'(inner);
                mul_b      = 33'(ees_pkg::PI_Q30);
                acc_op     = ACC_LOAD;
                state_next = S_CIRC_CAP;
            end

            S_CIRC_CAP:
            begin
                if (circ_w == '0)
                begin
                    rel_next   = (sup_total_reg != '0) ? ees_pkg::DIST_MAX : '0;
                    state_next = S_MEAN_SET;
                end
                else
                begin
                    acc_next   = 128'(sup_total_reg) <<< 16;
                    dsh_next   = 90'(circ_w) << 24;
                    quo_next   = '0;
                    iter_next  = '0;
                    dv_next    = DV_REL;
                    state_next = S_DIV;
                end
            end

            S_MEAN_SET:
            begin
                if (gpc_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    acc_next   = 128'(dist_total_reg);
                    dsh_next   = 90'(gpc_reg) << 24;
                    quo_next   = '0;
                    iter_next  = '0;
                    dv_next    = DV_MEAN;
                    state_next = S_DIV;
                end
            end

            S_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_rel_next    = rel_reg;
                    res_abs_next    = (sup_total_reg > 32'h1FFFFFF) ? '1 : sup_total_reg[24:0];
                    res_mean_next   = mean_reg;
                    sup_total_next  = '0;
                    dist_total_next = '0;
                    gpc_next        = '0;
                    sup_cnt_next    = '0;
                    arc_cnt_next    = '0;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        case (acc_op)
            ACC_LOAD: acc_next = prod_sh;
            ACC_ADD:  acc_next = acc_reg + prod_sh;
            ACC_SUB:  acc_next = acc_reg - prod_sh;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            iter_reg       <= '0;
            dv_reg         <= DV_DIST;
            sq_reg         <= SQ_PT;
            cx_reg         <= 16'd0;
            cy_reg         <= 16'd0;
            sa_reg         <= 16'd16;
            sb_reg         <= 16'd16;
            cos_reg        <= 16'd16384;
            sin_reg        <= 16'd0;
            thr_reg        <= 16'd256;
            sup_cnt_reg    <= '0;
            arc_cnt_reg    <= '0;
            gpc_reg        <= '0;
            sup_total_reg  <= '0;
            dist_total_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            iter_reg       <= iter_next;
            dv_reg         <= dv_next;
            sq_reg         <= sq_next;
            sup_cnt_reg    <= sup_cnt_next;
            arc_cnt_reg    <= arc_cnt_next;
            gpc_reg        <= gpc_next;
            sup_total_reg  <= sup_total_next;
            dist_total_reg <= dist_total_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_wr)
            begin
                case (ees_pkg::reg_idx_t'(paddr[4:2]))
                    ees_pkg::REG_CENTER_X:  cx_reg  <= pwdata[15:0];
                    ees_pkg::REG_CENTER_Y:  cy_reg  <= pwdata[15:0];
                    ees_pkg::REG_SEMI_MAJ:  sa_reg  <= pwdata[15:0];
                    ees_pkg::REG_SEMI_MIN:  sb_reg  <= pwdata[15:0];
                    ees_pkg::REG_COS:       cos_reg <= pwdata[15:0];
                    ees_pkg::REG_SIN:       sin_reg <= pwdata[15:0];
                    ees_pkg::REG_THRESHOLD: thr_reg <= pwdata[15:0];
                    default:                ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ptx_reg      <= ptx_next;
        pty_reg      <= pty_next;
        arc_end_reg  <= arc_end_next;
        grp_end_reg  <= grp_end_next;
        acc_reg      <= acc_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        uxb_reg      <= uxb_next;
        uya_reg      <= uya_next;
        uxbb_reg     <= uxbb_next;
        uyaa_reg     <= uyaa_next;
        ab_reg       <= ab_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        dist_reg     <= dist_next;
        rel_reg      <= rel_next;
        mean_reg     <= mean_next;
        res_rel_reg  <= res_rel_next;
        res_abs_reg  <= res_abs_next;
        res_mean_reg <= res_mean_next;
    end

    // one point at a time
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && pt.ready |=> !pt.ready)
        else $error("point taken while busy");

    // a score is only produced by a group-end point
    a_group_score: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> grp_end_reg)
        else $error("score without group end");

    a_arc_counts: assert property (@(posedge clk) disable iff (!rst_n)
        sup_cnt_reg <= arc_cnt_reg && arc_cnt_reg <= ARC_W'(MAX_ARC_POINTS))
        else $error("arc counts out of range");

    a_group_count: assert property (@(posedge clk) disable iff (!rst_n)
        gpc_reg <= GRP_W'(MAX_GROUP_POINTS))
        else $error("group count out of range");

    // totals cleared once the score is loaded
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && state_next == S_IDLE |=> gpc_reg == '0 && sup_total_reg == '0)
        else $error("totals not cleared after group");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for ellipse_edgel_support
// Drives edge points through the point channel, scores each accepted beat
// with an in-bench bit-exact predictor and checks every group score beat
// field by field. Register settings change only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [ees_pkg::COORD_W-1:0] x;
        logic [ees_pkg::COORD_W-1:0] y;
        logic                        arc_end;
        logic                        group_end;
    } edge_pt_t;

    typedef struct packed {
        logic [ees_pkg::REL_W-1:0]  rel;
        logic [ees_pkg::ABS_W-1:0]  abs_sup;
        logic [ees_pkg::MEAN_W-1:0] mean;
    } group_score_t;

    // drain time after the last score: worst point plus arc and group close
    localparam int DRAIN_CYCLES = 400;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ees_pkg::ADDR_W-1:0]   paddr;
    logic [ees_pkg::DATA_W-1:0]   pwdata;
    logic [ees_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    ees_point_if  pt_ch ();
    ees_result_if res_ch ();

    ellipse_edgel_support i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pt      (pt_ch),
        .res     (res_ch)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    edge_pt_t     point_q[$];     // points waiting to be driven
    group_score_t score_q[$];     // predicted group scores, oldest first
    logic [15:0]  cfg_regs[7];    // shadow of the register file

    int tx_idle_pct;
    int rx_idle_pct;
    int n_queued;
    int n_accepted;
    int n_groups;
    int n_scores;
    int n_errors;
    int n_settings;

    // predictor state
    int unsigned       arc_sup_cnt;
    int unsigned       arc_pt_cnt;
    int unsigned       grp_pt_cnt;
    longint unsigned   sup_total;
    longint unsigned   dist_total;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Gradient-weighted algebraic distance of rotated point (qx, qy), Q16.8.
    function automatic logic [23:0] edge_dist(longint qx, longint qy);
        logic [127:0] ux, uy, amaj, bmin, ub, ua, m2, root, p2, q2, num, den, t;
        logic [23:0]  quo;
        int           k;
        if (qx == 0 && qy == 0)
            return {4'd0, cfg_regs[ees_pkg::REG_SEMI_MIN], 4'd0};
        ux   = (qx < 0) ? -qx : qx;
        uy   = (qy < 0) ? -qy : qy;
        amaj = {108'd0, cfg_regs[ees_pkg::REG_SEMI_MAJ], 4'd0};
        bmin = {108'd0, cfg_regs[ees_pkg::REG_SEMI_MIN], 4'd0};
        ub   = ux * bmin * bmin;
        ua   = uy * amaj * amaj;
        m2   = ub * ub + ua * ua;
        root = '0;
        for (k = 63; k >= 0; k--)
        begin
            t = root | (128'd1 << k);
            if (t * t <= m2)
                root = t;
        end
        if (root == 0)
            return ees_pkg::DIST_MAX;
        p2  = (ux * bmin) * (ux * bmin) + (uy * amaj) * (uy * amaj);
        q2  = (amaj * bmin) * (amaj * bmin);
        num = (q2 <= p2) ? p2 - q2 : q2 - p2;
        den = root << 1;
        if ((den << 24) <= num)
            return ees_pkg::DIST_MAX;
        quo = '0;
        for (k = 23; k >= 0; k--)
        begin
            t = {104'd0, quo | (24'd1 << k)};
            if (t * den <= num)
                quo = t[23:0];
        end
        return quo;
    endfunction

    // Approximate circumference pi*(1.5(a+b) - sqrt(ab)) in Q.8.
    function automatic longint unsigned circ_q8();
        longint unsigned ab, r, t, inner;
        int              k;
        ab = (longint'(cfg_regs[ees_pkg::REG_SEMI_MAJ]) * cfg_regs[ees_pkg::REG_SEMI_MIN]) << 8;
        r  = 0;
        for (k = 20; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= ab)
                r = t;
        end
        inner = 24 * (longint'(cfg_regs[ees_pkg::REG_SEMI_MAJ])
                      + cfg_regs[ees_pkg::REG_SEMI_MIN]) - r;
        return (inner * ees_pkg::PI_Q30 + (64'd1 << 29)) >> 30;
    endfunction

    // Fold one accepted point into the sums; queue a score at group end.
    function automatic void score_point(edge_pt_t p);
        longint          px, py, c, s, qx, qy;
        logic [23:0]     d;
        longint unsigned circ, rel, mean;
        group_score_t    sc;
        px = longint'(p.x) - longint'(cfg_regs[ees_pkg::REG_CENTER_X]);
        py = longint'(p.y) - longint'(cfg_regs[ees_pkg::REG_CENTER_Y]);
        c  = longint'($signed(cfg_regs[ees_pkg::REG_COS]));
        s  = longint'($signed(cfg_regs[ees_pkg::REG_SIN]));
        qx = (c * px + s * py + 512) >>> 10;
        qy = (c * py - s * px + 512) >>> 10;
        d  = edge_dist(qx, qy);
        if (arc_pt_cnt < ees_pkg::MAX_ARC_POINTS_DEF)
        begin
            arc_pt_cnt++;
            if (d <= cfg_regs[ees_pkg::REG_THRESHOLD])
                arc_sup_cnt++;
        end
        if (grp_pt_cnt < ees_pkg::MAX_GROUP_POINTS_DEF)
        begin
            grp_pt_cnt++;
            dist_total += d;
            if (dist_total > 64'hFFFF_FFFF_FFFF)
                dist_total = 64'hFFFF_FFFF_FFFF;
        end
        if (p.arc_end || p.group_end)
        begin
            if (arc_pt_cnt != 0)
            begin
                sup_total += ((longint'(arc_sup_cnt) * arc_sup_cnt) << 8) / arc_pt_cnt;
                if (sup_total > 64'hFFFF_FFFF)
                    sup_total = 64'hFFFF_FFFF;
            end
            arc_sup_cnt = 0;
            arc_pt_cnt  = 0;
        end
        if (!p.group_end)
            return;
        circ = circ_q8();
        if (circ == 0)
            rel = (sup_total != 0) ? ees_pkg::DIST_MAX : 0;
        else
            rel = (sup_total << 16) / circ;
        if (rel > ees_pkg::DIST_MAX)
            rel = ees_pkg::DIST_MAX;
        mean = (grp_pt_cnt != 0) ? dist_total / grp_pt_cnt : 0;
        if (mean > ees_pkg::DIST_MAX)
            mean = ees_pkg::DIST_MAX;
        sc.rel     = rel[23:0];
        sc.abs_sup = (sup_total > 64'h1FF_FFFF) ? 25'h1FF_FFFF : sup_total[24:0];
        sc.mean    = mean[23:0];
        score_q.push_back(sc);
        sup_total  = 0;
        dist_total = 0;
        grp_pt_cnt = 0;
    endfunction

    // ------------------------------------------------------------------
    // Point driver: next beat goes out once the current one is taken
    // ------------------------------------------------------------------
    edge_pt_t drv_pt;

    always @(posedge clk)
    begin
        if (!rst_n)
            pt_ch.valid <= 1'b0;
        else if (!pt_ch.valid || pt_ch.ready)
        begin
            if (point_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                drv_pt = point_q.pop_front();
                pt_ch.valid      <= 1'b1;
                pt_ch.point_x    <= drv_pt.x;
                pt_ch.point_y    <= drv_pt.y;
                pt_ch.arc_last   <= drv_pt.arc_end;
                pt_ch.group_last <= drv_pt.group_end;
            end
            else
                pt_ch.valid <= 1'b0;
        end
    end

    // accepted point beats feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && pt_ch.valid && pt_ch.ready)
        begin
            score_point('{pt_ch.point_x, pt_ch.point_y, pt_ch.arc_last, pt_ch.group_last});
            n_accepted++;
        end
    end

    // score receiver stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Score monitor: compare each beat with the oldest prediction
    // ------------------------------------------------------------------
    group_score_t exp_sc;

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            n_scores++;
            if (score_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected score beat rel=%0d abs=%0d mean=%0d",
                             res_ch.relative_support, res_ch.absolute_support,
                             res_ch.mean_fit_error);
            end
            else
            begin
                exp_sc = score_q.pop_front();
                if (res_ch.relative_support !== exp_sc.rel
                    || res_ch.absolute_support !== exp_sc.abs_sup
                    || res_ch.mean_fit_error !== exp_sc.mean)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: score %0d exp rel/abs/mean=%0d/%0d/%0d got %0d/%0d/%0d",
                                 n_scores, exp_sc.rel, exp_sc.abs_sup, exp_sc.mean,
                                 res_ch.relative_support, res_ch.absolute_support,
                                 res_ch.mean_fit_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_point(int x, int y, bit arc_end, bit group_end);
        edge_pt_t p;
        p.x         = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
        p.y         = (y < 0) ? 16'd0 : (y > 65535) ? 16'hFFFF : y[15:0];
        p.arc_end   = arc_end;
        p.group_end = group_end;
        point_q.push_back(p);
        n_queued++;
        if (group_end)
            n_groups++;
    endtask

    // a setup phase and then an access phase; the register takes the data on the access edge
    task automatic reg_write(ees_pkg::reg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ees_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= {16'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_regs[idx] = val;
    endtask

    task automatic wait_idle();
        wait (n_accepted == n_queued && score_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(int cx, int cy, int a, int b, int c, int s, int thr);
        logic [15:0] vals[7];
        vals = '{cx[15:0], cy[15:0], a[15:0], b[15:0], c[15:0], s[15:0], thr[15:0]};
        wait_idle();
        for (int i = 0; i < 7; i++)
            reg_write(ees_pkg::reg_idx_t'(i), vals[i]);
        n_settings++;
    endtask

    // A point near the configured ellipse, or a random one as noise.
    task automatic add_arc_point(bit noise, bit arc_end, bit group_end);
        real ang, ca, sa, ex, ey, jx, jy;
        if (noise)
            add_point($urandom_range(0, 65535), $urandom_range(0, 65535), arc_end, group_end);
        else
        begin
            ang = $urandom_range(0, 3599) * 3.14159265 / 1800.0;
            ca  = $itor($signed(cfg_regs[ees_pkg::REG_COS])) / 16384.0;
            sa  = $itor($signed(cfg_regs[ees_pkg::REG_SIN])) / 16384.0;
            ex  = cfg_regs[ees_pkg::REG_SEMI_MAJ] * $cos(ang);
            ey  = cfg_regs[ees_pkg::REG_SEMI_MIN] * $sin(ang);
            jx  = $itor($urandom_range(0, 48)) - 24.0;
            jy  = $itor($urandom_range(0, 48)) - 24.0;
            add_point(cfg_regs[ees_pkg::REG_CENTER_X] + $rtoi(ex * ca - ey * sa + jx),
                      cfg_regs[ees_pkg::REG_CENTER_Y] + $rtoi(ex * sa + ey * ca + jy),
                      arc_end, group_end);
        end
    endtask

    // A group of a few arcs; mostly on-ellipse points with random noise mixed in.
    task automatic add_group();
        int n_arcs, len;
        n_arcs = $urandom_range(1, 5);
        for (int a = 0; a < n_arcs; a++)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                add_arc_point($urandom_range(0, 99) < 20, i == len - 1,
                              a == n_arcs - 1 && i == len - 1);
        end
    endtask

    task automatic run_groups(int n_points);
        int start;
        start = n_queued;
        while (n_queued - start < n_points)
        begin
            add_group();
            wait (point_q.size() < 16);
        end
    endtask

    task automatic random_setting();
        real th;
        int  a;
        th = $urandom_range(0, 359) * 3.14159265 / 180.0;
        a  = $urandom_range(64, 4000);
        load_setting($urandom_range(20000, 40000), $urandom_range(20000, 40000), a,
                     $urandom_range(64, a), $rtoi(16384.0 * $cos(th)),
                     $rtoi(16384.0 * $sin(th)), $urandom_range(0, 2048));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        tx_idle_pct  = 22;
        rx_idle_pct  = 67;
        n_queued     = 0;
        n_accepted   = 0;
        n_groups     = 0;
        n_scores     = 0;
        n_errors     = 0;
        n_settings   = 0;
        arc_sup_cnt  = 0;
        arc_pt_cnt   = 0;
        grp_pt_cnt   = 0;
        sup_total    = 0;
        dist_total   = 0;
        // reset defaults: centre 0, axes 1 pixel, no rotation, threshold 1 pixel
        cfg_regs = '{16'd0, 16'd0, 16'd16, 16'd16, 16'd16384, 16'd0, 16'd256};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default circle of radius one pixel about the origin
        add_point(0, 0, 1'b0, 1'b1);            // point at the centre
        add_point(16, 0, 1'b0, 1'b0);           // on the circle
        add_point(0, 16, 1'b1, 1'b0);           // on the circle, arc end
        add_point(65535, 65535, 1'b0, 1'b0);    // far corner
        add_point(65535, 0, 1'b1, 1'b0);
        add_point(0, 65535, 1'b0, 1'b0);
        add_point(16, 16, 1'b1, 1'b1);          // arc end and group end together
        add_point(32, 0, 1'b0, 1'b1);           // group end alone closes the arc
        add_point(21845, 43690, 1'b0, 1'b1);    // alternating bit patterns
        add_point(43690, 21845, 1'b1, 1'b1);
        // arc ends without group end, then a lone group end
        add_point(8, 8, 1'b1, 1'b0);
        add_point(0, 8, 1'b1, 1'b0);
        add_point(8, 0, 1'b0, 1'b1);

        // extremes: large axes at the origin, quarter turn, widest threshold
        load_setting(0, 0, 65535, 65535, 0, 16384, 65535);
        add_point(0, 0, 1'b0, 1'b1);
        add_point(65535, 65535, 1'b1, 1'b0);
        add_point(65535, 0, 1'b0, 1'b1);
        run_groups(200);

        // smallest axes at the far corner, zero threshold, reversed turn
        load_setting(65535, 65535, 1, 1, 0, -16384, 0);
        add_point(65535, 65535, 1'b0, 1'b1);    // centre: distance is b
        add_point(0, 0, 1'b1, 1'b1);
        run_groups(200);

        load_setting(16000, 16000, 1600, 800, 14189, 8192, 256);
        run_groups(300);

        // receiver keeps up, sender stalls
        tx_idle_pct = 67;
        rx_idle_pct = 22;
        load_setting(8000, 24000, 480, 480, -16384, 0, 64);
        add_point(8000, 24000, 1'b0, 1'b1);
        run_groups(250);
        load_setting(32768, 32768, 3200, 160, -11585, 11585, 1024);
        run_groups(250);

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_setting();
        run_groups(250);
        random_setting();
        run_groups(250);

        wait_idle();
        $display("Covered %0d points in %0d groups over %0d register settings,",
                 n_accepted, n_groups, n_settings);
        $display("%0d scores checked, %0d mismatches.", n_scores, n_errors);
        if (n_errors == 0 && score_q.size() == 0)
            $display("ellipse_edgel_support regression: pass");
        else
            $display("ellipse_edgel_support regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("ellipse_edgel_support regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ees_pkg.sv
design/ees_point_if.sv
design/ees_result_if.sv
design/ellipse_edgel_support.sv
bench/tb_top.sv
